// ===== hw/rtl/mailbox_link_handshake_assert.svh =====
// Assertion macros for the mailbox link handshake block.
// Used by mailbox_link_handshake.sv; the bodies are empty in synthesis.
`ifndef MAILBOX_LINK_HANDSHAKE_ASSERT_SVH
`define MAILBOX_LINK_HANDSHAKE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define MLH_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mailbox link handshake assertion failed");
// Checked at every edge, also during reset.
`define MLH_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("mailbox link handshake assertion failed");
`else
`define MLH_ASSERT(name, prop)
`define MLH_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== hw/rtl/mlh_pkg.sv =====
// Types and constants of the mailbox link handshake block.
// Used by mailbox_link_handshake.sv; depends on nothing else.
`timescale 1ns / 1ps

package mlh_pkg;

  localparam logic [31:0] LinkMagic   = 32'h4d41494c;
  localparam logic [31:0] LinkVersion = 32'h0000_0001;
  localparam logic [31:0] StateUp     = 32'h0000ffff;
  localparam logic [31:0] StateDown   = 32'hffff0000;

  localparam logic [31:0] AddrRemoteLinkAck = 32'h10;
  localparam logic [31:0] AddrRemoteChAck   = 32'h18;
  localparam logic [31:0] AddrLocalLink     = 32'h24;
  localparam logic [31:0] AddrLocalCh       = 32'h2c;

  localparam logic [15:0] TimeoutReset = 16'd100;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_OPEN   = 3'd1,
    OP_CLOSE  = 3'd2,
    OP_SEND   = 3'd3,
    OP_UPDATE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    PH_CLOSED   = 3'd0,
    PH_LINK_ACK = 3'd1,
    PH_CH_UP    = 3'd2,
    PH_CH_ACK   = 3'd3,
    PH_OPEN     = 3'd4,
    PH_SENDING  = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    ST_PENDING     = 4'd0,
    ST_OPENED      = 4'd1,
    ST_SENT        = 4'd2,
    ST_BAD_MAGIC   = 4'd3,
    ST_BAD_VERSION = 4'd4,
    ST_BAD_SIZE    = 4'd5,
    ST_TIMEOUT     = 4'd6,
    ST_BAD_LEN     = 4'd7,
    ST_IGNORED     = 4'd8,
    ST_CLOSED      = 4'd9
  } status_e;

  // One message RAM write (or a bare status beat when we is low).
  typedef struct packed {
    logic        we;
    logic [31:0] addr;
    logic [31:0] data;
    logic        kick;
  } res_t;

endpackage

// ===== hw/rtl/mailbox_link_handshake.sv =====
// Local side of a shared-RAM mailbox link: event decode, link state and result beats.
// Depends on mlh_pkg and mailbox_link_handshake_assert.svh.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one event per beat: tick, open,
//   close, send or remote update, with the descriptor words the partner wrote. The output
//   channel (out_valid_o / out_stall_i) returns one or two beats per event, each a message
//   RAM write request or a bare status; last_o marks the final beat of an event and all
//   beats of one event carry the same status. The user must write the timeout register
//   via cfg_wr_en_i / cfg_wr_data_i only while the block is idle; this is not enforced.
//   An accepted event waits in the input register until the result register is free; its
//   result beats are then registered into the result register and presented from there.
//   The event logic runs in a single pass, so the block takes a new event every cycle as
//   long as each event yields one beat and the receiver does not stall; an event with two
//   beats holds the result register until both are taken, and the event behind it waits.
//   Reset closes the link, clears the wait counter and the latched mailbox window, sets
//   the timeout to 100 ticks and empties both registers.
//   While the receiver stalls, the result beat holds; the input register still takes one
//   more event, and then in_stall_o rises until the result register drains.
`timescale 1ns / 1ps
`include "mailbox_link_handshake_assert.svh"

module mailbox_link_handshake (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] magic_word_i,
  input  logic [31:0] version_word_i,
  input  logic [31:0] mailbox_offset_word_i,
  input  logic [31:0] mailbox_size_word_i,
  input  logic [31:0] remote_link_word_i,
  input  logic [31:0] link_ack_word_i,
  input  logic [31:0] remote_channel_word_i,
  input  logic [31:0] channel_ack_word_i,
  input  logic [31:0] message_head_word_i,
  input  logic [15:0] send_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_enable_o,
  output logic [31:0] write_address_o,
  output logic [31:0] write_data_o,
  output logic        kick_o,
  output logic [3:0]  status_o,
  output logic        last_o
);
  import mlh_pkg::*;

  // Input register.
  logic        in_vld_q;
  logic [2:0]  op_q;
  logic [31:0] magic_q, version_q, off_w_q, size_w_q;
  logic [31:0] rlink_q, lack_q, rch_q, chack_q, head_q;
  logic [15:0] len_q;

  // Link state.
  phase_e      phase_q, phase_d;
  logic [15:0] wait_q, wait_d;
  logic [31:0] off_q, off_d;
  logic [31:0] size_q, size_d;
  logic [15:0] timeout_q;

  // Result register: up to two beats of one event.
  res_t        res_q [2];
  res_t        r0_d, r1_d;
  logic [1:0]  res_cnt_q, cnt_d;
  logic        res_idx_q;
  status_e     status_q, status_d;

  logic        in_take, out_take, res_last, advance;
  logic        met, expire, bad_len;
  logic [16:0] next_wait;
  logic [32:0] len_plus;

  assign res_last = (res_cnt_q == 2'd1) || res_idx_q;
  assign out_valid_o = (res_cnt_q != 2'd0);
  assign out_take = out_valid_o && !out_stall_i;
  // The event in the input register moves on once the result register is free.
  assign advance = in_vld_q && ((res_cnt_q == 2'd0) || (out_take && res_last));
  assign in_stall_o = in_vld_q && !advance;
  assign in_take = in_valid_i && !in_stall_o;

  assign write_enable_o  = res_q[res_idx_q].we;
  assign write_address_o = res_q[res_idx_q].addr;
  assign write_data_o    = res_q[res_idx_q].data;
  assign kick_o          = res_q[res_idx_q].kick;
  assign status_o        = status_q;
  assign last_o          = res_last;

  assign next_wait = {1'b0, wait_q} + 17'd1;
  assign expire    = (op_q == OP_TICK) && (next_wait >= {1'b0, timeout_q});
  assign len_plus  = {17'd0, len_q} + 33'd4;
  assign bad_len   = (len_q[1:0] != 2'b00) || (len_plus > {1'b0, size_q});

  always_comb begin
    unique case (phase_q)
      PH_LINK_ACK: met = (lack_q == StateUp);
      PH_CH_UP:    met = (rch_q == StateUp);
      PH_CH_ACK:   met = (chack_q == StateUp);
      default:     met = (head_q == 32'd0);
    endcase
  end

  always_comb begin
    r0_d     = '0;
    r1_d     = '0;
    cnt_d    = 2'd0;
    status_d = ST_IGNORED;
    phase_d  = phase_q;
    wait_d   = wait_q;
    off_d    = off_q;
    size_d   = size_q;
    priority if (op_q == OP_CLOSE) begin
      r0_d     = '{we: 1'b1, addr: AddrLocalCh, data: StateDown, kick: 1'b0};
      r1_d     = '{we: 1'b1, addr: AddrLocalLink, data: StateDown, kick: 1'b1};
      cnt_d    = 2'd2;
      status_d = ST_CLOSED;
      phase_d  = PH_CLOSED;
      wait_d   = '0;
    end else if (op_q == OP_OPEN && phase_q == PH_CLOSED) begin
      if (magic_q != LinkMagic) begin
        status_d = ST_BAD_MAGIC;
      end else if (version_q != LinkVersion) begin
        status_d = ST_BAD_VERSION;
      end else begin
        off_d  = off_w_q;
        size_d = size_w_q;
        if (size_w_q == 32'd0) begin
          status_d = ST_BAD_SIZE;
        end else begin
          r0_d     = '{we: 1'b1, addr: AddrRemoteLinkAck, data: rlink_q, kick: 1'b0};
          r1_d     = '{we: 1'b1, addr: AddrLocalLink, data: StateUp, kick: 1'b1};
          cnt_d    = 2'd2;
          status_d = ST_PENDING;
          phase_d  = PH_LINK_ACK;
          wait_d   = '0;
        end
      end
    end else if (op_q == OP_SEND && phase_q == PH_OPEN) begin
      if (bad_len) begin
        status_d = ST_BAD_LEN;
      end else begin
        r0_d     = '{we: 1'b1, addr: off_q, data: {16'd0, len_q}, kick: 1'b1};
        cnt_d    = 2'd1;
        status_d = ST_PENDING;
        phase_d  = PH_SENDING;
        wait_d   = '0;
      end
    end else if ((op_q == OP_TICK || op_q == OP_UPDATE) &&
                 phase_q != PH_CLOSED && phase_q != PH_OPEN) begin
      if (met) begin
        wait_d   = '0;
        status_d = ST_PENDING;
        unique case (phase_q)
          PH_LINK_ACK: begin
            r0_d    = '{we: 1'b1, addr: AddrLocalCh, data: StateUp, kick: 1'b1};
            cnt_d   = 2'd1;
            phase_d = PH_CH_UP;
          end
          PH_CH_UP: begin
            r0_d    = '{we: 1'b1, addr: AddrRemoteChAck, data: StateUp, kick: 1'b1};
            cnt_d   = 2'd1;
            phase_d = PH_CH_ACK;
          end
          PH_CH_ACK: begin
            status_d = ST_OPENED;
            phase_d  = PH_OPEN;
          end
          default: begin
            status_d = ST_SENT;
            phase_d  = PH_OPEN;
          end
        endcase
      end else if (expire) begin
        wait_d   = '0;
        status_d = ST_TIMEOUT;
        priority if (phase_q == PH_SENDING) begin
          // Withdraw the message header; the link itself stays open.
          r0_d    = '{we: 1'b1, addr: off_q, data: 32'd0, kick: 1'b0};
          cnt_d   = 2'd1;
          phase_d = PH_OPEN;
        end else if (phase_q == PH_LINK_ACK) begin
          r0_d    = '{we: 1'b1, addr: AddrLocalLink, data: StateDown, kick: 1'b1};
          cnt_d   = 2'd1;
          phase_d = PH_CLOSED;
        end else begin
          r0_d    = '{we: 1'b1, addr: AddrLocalCh, data: StateDown, kick: 1'b0};
          r1_d    = '{we: 1'b1, addr: AddrLocalLink, data: StateDown, kick: 1'b1};
          cnt_d   = 2'd2;
          phase_d = PH_CLOSED;
        end
      end else begin
        if (op_q == OP_TICK) begin
          wait_d = next_wait[15:0];
        end
        status_d = ST_PENDING;
      end
    end else begin
      // Misplaced requests and unused operation codes are ignored.
      status_d = ST_IGNORED;
    end
    // Every event answers with at least one beat.
    if (cnt_d == 2'd0) begin
      cnt_d = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_wr_en_i) begin
      timeout_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q      <= operation_i;
      magic_q   <= magic_word_i;
      version_q <= version_word_i;
      off_w_q   <= mailbox_offset_word_i;
      size_w_q  <= mailbox_size_word_i;
      rlink_q   <= remote_link_word_i;
      lack_q    <= link_ack_word_i;
      rch_q     <= remote_channel_word_i;
      chack_q   <= channel_ack_word_i;
      head_q    <= message_head_word_i;
      len_q     <= send_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CLOSED;
      wait_q  <= '0;
      off_q   <= '0;
      size_q  <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      off_q   <= off_d;
      size_q  <= size_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
      res_idx_q <= 1'b0;
    end else if (advance) begin
      res_cnt_q <= cnt_d;
      res_idx_q <= 1'b0;
    end else if (out_take) begin
      if (res_last) begin
        res_cnt_q <= 2'd0;
        res_idx_q <= 1'b0;
      end else begin
        res_idx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q[0] <= r0_d;
      res_q[1] <= r1_d;
      status_q <= status_d;
    end
  end

  `MLH_ASSERT(a_idx_in_range, res_idx_q |-> (res_cnt_q == 2'd2))
  `MLH_ASSERT(a_event_yields_beat, advance |=> (res_cnt_q != 2'd0) && !res_idx_q)
  `MLH_ASSERT(a_idle_phase_no_count, (phase_q == PH_CLOSED || phase_q == PH_OPEN) |-> (wait_q == 16'd0))
  `MLH_ASSERT_ALWAYS(a_no_stall_when_empty, !in_vld_q |-> !in_stall_o)

endmodule
